// ===== hdl/nps_pkg.sv =====
// Package for the priority scheduler with aging.
// Types, field widths, slot record layout and helper functions; no dependencies.
package nps_pkg;

  localparam int unsigned PrioW  = 8;
  localparam int unsigned IdW    = 16;
  localparam int unsigned BurstW = 16;
  localparam int unsigned WaitW  = 16;
  localparam int unsigned PhaseW = 8;
  localparam int unsigned TurnW  = 17;
  localparam int unsigned CountW = 5;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 104;

  localparam logic [CfgIdxW-1:0] CfgAgingPeriod   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgPriorityFloor = 8'd1;

  localparam logic [PrioW-1:0] AgingPeriodRst   = 8'd3;
  localparam logic [PrioW-1:0] PriorityFloorRst = 8'd1;
  localparam logic [WaitW-1:0] WaitMax          = 16'hFFFF;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PrioW-1:0]  prio;
    logic [BurstW-1:0] burst;
    logic [WaitW-1:0]  wait_cnt;
    logic [PhaseW-1:0] phase;
  } slot_rec_t;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StScan   = 7'b0000010,
    StSDrain = 7'b0000100,
    StDisp   = 7'b0001000,
    StAge    = 7'b0010000,
    StADrain = 7'b0100000,
    StFin    = 7'b1000000
  } state_e;

  typedef struct packed {
    logic start;
    logic scan_rd;
    logic age_rd;
    logic disp;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_pending;
  } status_t;

  function automatic logic better(input logic [PrioW-1:0] ap, input logic [IdW-1:0] aid,
                                  input logic [PrioW-1:0] bp, input logic [IdW-1:0] bid);
    better = (ap < bp) || ((ap == bp) && (aid < bid));
  endfunction

  function automatic slot_rec_t age_rec(input slot_rec_t r, input logic [PrioW-1:0] period,
                                        input logic [PrioW-1:0] floor_v);
    slot_rec_t o;
    logic [PhaseW-1:0] ph;
    o = r;
    if (r.wait_cnt != WaitMax) begin
      o.wait_cnt = r.wait_cnt + 16'd1;
    end
    ph = r.phase + 8'd1;
    if (ph == period) begin
      ph = '0;
      if (r.prio > floor_v) begin
        o.prio = r.prio - 8'd1;
      end
    end
    o.phase = ph;
    age_rec = o;
  endfunction

endpackage

// ===== hdl/nps_ctrl.sv =====
// Controller FSM of the priority scheduler: sequences scan, dispatch and aging passes.
// Depends on nps_pkg.
module nps_ctrl #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  nps_pkg::status_t         status_i,
  output nps_pkg::cmd_t            cmd_o,
  output logic [$clog2(SLOTS)-1:0] addr_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] Last = IW'(SLOTS - 1);

  nps_pkg::state_e state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == nps_pkg::StIdle);
  assign addr_o = cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      nps_pkg::StIdle: begin
        cnt_d = '0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = nps_pkg::StScan;
        end
      end
      nps_pkg::StScan: begin
        cmd_o.scan_rd = 1'b1;
        if (cnt_q == Last) begin
          cnt_d = '0;
          state_d = nps_pkg::StSDrain;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      nps_pkg::StSDrain: state_d = nps_pkg::StDisp;
      nps_pkg::StDisp: begin
        cmd_o.disp = 1'b1;
        state_d = nps_pkg::StAge;
      end
      nps_pkg::StAge: begin
        cmd_o.age_rd = 1'b1;
        if (cnt_q == Last) begin
          cnt_d = '0;
          state_d = nps_pkg::StADrain;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      nps_pkg::StADrain: state_d = nps_pkg::StFin;
      nps_pkg::StFin: begin
        if (!status_i.out_pending) begin
          cmd_o.load_out = 1'b1;
          state_d = nps_pkg::StIdle;
        end
      end
      default: state_d = nps_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nps_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/nps_datapath.sv =====
// Datapath of the priority scheduler: slot memory, valid bits, running job,
// selection and aging logic, config and result registers. Depends on nps_pkg.
module nps_datapath #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  nps_pkg::cmd_t                      cmd_i,
  input  logic [$clog2(SLOTS)-1:0]           addr_i,
  output nps_pkg::status_t                   status_o,
  input  logic [nps_pkg::InDataW-1:0]        in_data_i,
  input  logic                               cfg_valid_i,
  input  logic [nps_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [nps_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [nps_pkg::OutDataW-1:0]       out_data_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  nps_pkg::slot_rec_t mem [SLOTS];
  logic [SLOTS-1:0] valid_q, valid_d;

  nps_pkg::slot_rec_t rdata_q;
  logic rvld_q, rage_q;
  logic [IW-1:0] ridx_q;

  logic                        in_arrive_q;
  logic [nps_pkg::PrioW-1:0]   in_prio_q;
  logic [nps_pkg::BurstW-1:0]  in_burst_q;

  logic free_found_q, free_found_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic best_found_q, best_found_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  nps_pkg::slot_rec_t best_q, best_d;

  logic                        run_valid_q, run_valid_d;
  logic [nps_pkg::IdW-1:0]     run_id_q, run_id_d;
  logic [nps_pkg::BurstW-1:0]  run_rem_q, run_rem_d;
  logic [nps_pkg::PrioW-1:0]   run_prio_q, run_prio_d;
  logic [nps_pkg::IdW-1:0]     id_q, id_d;

  logic                        disp_q, disp_d, drop_q, drop_d;
  logic [nps_pkg::IdW-1:0]     d_id_q, d_id_d;
  logic [nps_pkg::WaitW-1:0]   d_wait_q, d_wait_d;
  logic [nps_pkg::TurnW-1:0]   d_turn_q, d_turn_d;
  logic [CW-1:0]               count_q, count_d;

  logic [nps_pkg::PrioW-1:0]   period_q, floor_q;
  logic                        out_valid_q;
  logic [nps_pkg::OutDataW-1:0] out_data_q;

  logic                        we;
  logic [IW-1:0]               waddr;
  nps_pkg::slot_rec_t          wdata, new_rec, cand;
  logic                        place, new_wins, have_cand, need_disp, idle_flag;
  logic [IW-1:0]               sel_idx;

  assign status_o.out_pending = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    new_rec = '{id: id_q, prio: in_prio_q, burst: in_burst_q, wait_cnt: '0, phase: '0};
    place     = in_arrive_q && free_found_q;
    new_wins  = place && (!best_found_q ||
                nps_pkg::better(in_prio_q, id_q, best_q.prio, best_q.id));
    have_cand = place || best_found_q;
    cand      = new_wins ? new_rec : best_q;
    sel_idx   = new_wins ? free_idx_q : best_idx_q;
    need_disp = !run_valid_q || (run_rem_q == '0);
  end

  always_comb begin
    valid_d      = valid_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    run_valid_d  = run_valid_q;
    run_id_d     = run_id_q;
    run_rem_d    = run_rem_q;
    run_prio_d   = run_prio_q;
    id_d         = id_q;
    disp_d       = disp_q;
    drop_d       = drop_q;
    d_id_d       = d_id_q;
    d_wait_d     = d_wait_q;
    d_turn_d     = d_turn_q;
    count_d      = count_q;
    we           = 1'b0;
    waddr        = ridx_q;
    wdata        = nps_pkg::age_rec(rdata_q, period_q, floor_q);

    if (cmd_i.start) begin
      free_found_d = 1'b0;
      best_found_d = 1'b0;
      count_d      = '0;
    end

    if (rvld_q && !rage_q) begin
      if (!valid_q[ridx_q]) begin
        if (!free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = ridx_q;
        end
      end else if (!best_found_q ||
                   nps_pkg::better(rdata_q.prio, rdata_q.id, best_q.prio, best_q.id)) begin
        best_found_d = 1'b1;
        best_idx_d   = ridx_q;
        best_d       = rdata_q;
      end
    end

    if (rvld_q && rage_q && valid_q[ridx_q]) begin
      we      = 1'b1;
      count_d = count_q + 1'b1;
    end

    if (cmd_i.disp) begin
      drop_d   = in_arrive_q && !free_found_q;
      disp_d   = 1'b0;
      d_id_d   = '0;
      d_wait_d = '0;
      d_turn_d = '0;
      if (place) begin
        we    = 1'b1;
        waddr = free_idx_q;
        wdata = new_rec;
        valid_d[free_idx_q] = 1'b1;
        id_d  = id_q + 1'b1;
      end
      if (need_disp) begin
        run_valid_d = 1'b0;
        if (have_cand) begin
          valid_d[sel_idx] = 1'b0;
          run_valid_d = 1'b1;
          run_id_d    = cand.id;
          run_rem_d   = cand.burst;
          run_prio_d  = cand.prio;
          disp_d      = 1'b1;
          d_id_d      = cand.id;
          d_wait_d    = cand.wait_cnt;
          d_turn_d    = {1'b0, cand.wait_cnt} + {1'b0, cand.burst};
        end
      end
      if (run_valid_d && (run_rem_d != '0)) begin
        run_rem_d = run_rem_d - 1'b1;
      end
    end
  end

  assign idle_flag = (count_q == '0) && !(run_valid_q && (run_rem_q != '0));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.scan_rd || cmd_i.age_rd) begin
      rdata_q <= mem[addr_i];
    end
    ridx_q <= addr_i;
    rage_q <= cmd_i.age_rd;
    if (cmd_i.start) begin
      in_arrive_q <= in_data_i[0];
      in_prio_q   <= in_data_i[8:1];
      in_burst_q  <= in_data_i[24:9];
    end
    free_idx_q <= free_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    d_id_q     <= d_id_d;
    d_wait_q   <= d_wait_d;
    d_turn_q   <= d_turn_d;
    count_q    <= count_d;
    if (cmd_i.load_out) begin
      out_data_q <= {6'd0, idle_flag, drop_q, d_turn_q, d_wait_q, d_id_q, disp_q,
                     count_q[nps_pkg::CountW-1:0],
                     run_valid_q ? run_prio_q : '0,
                     run_valid_q ? run_rem_q : '0,
                     run_valid_q ? run_id_q : '0,
                     run_valid_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      rvld_q       <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      run_valid_q  <= 1'b0;
      run_id_q     <= '0;
      run_rem_q    <= '0;
      run_prio_q   <= '0;
      id_q         <= 16'd1;
      disp_q       <= 1'b0;
      drop_q       <= 1'b0;
      period_q     <= nps_pkg::AgingPeriodRst;
      floor_q      <= nps_pkg::PriorityFloorRst;
      out_valid_q  <= 1'b0;
    end else begin
      valid_q      <= valid_d;
      rvld_q       <= cmd_i.scan_rd || cmd_i.age_rd;
      free_found_q <= free_found_d;
      best_found_q <= best_found_d;
      run_valid_q  <= run_valid_d;
      run_id_q     <= run_id_d;
      run_rem_q    <= run_rem_d;
      run_prio_q   <= run_prio_d;
      id_q         <= id_d;
      disp_q       <= disp_d;
      drop_q       <= drop_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == nps_pkg::CfgAgingPeriod) begin
          period_q <= cfg_data_i;
        end else if (cfg_index_i == nps_pkg::CfgPriorityFloor) begin
          floor_q <= cfg_data_i;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/nonpreemptive_priority_scheduler_aging.sv =====
// Non-preemptive priority scheduler with aging, one input item per tick.
// An accepted item goes through a scan pass and an aging pass, which each read
// the slot memory once per slot through its single read port. A new item is taken
// only once the controller is back in idle, after the result has been loaded.
// Reset (async, active low): table empty, no job running, next ID 1,
// aging_period 3, priority_floor 1. Depends on nps_pkg, nps_ctrl, nps_datapath.
module nonpreemptive_priority_scheduler_aging #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // arrive[0], job_priority[8:1], job_burst[24:9], zero fill
  input  logic [nps_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // running_valid[0], running_id[16:1], running_remaining[32:17],
  // running_priority[40:33], ready_count[45:41], dispatched[46],
  // dispatched_id[62:47], dispatched_wait[78:63], dispatched_turnaround[95:79],
  // arrival_dropped[96], all_idle[97], zero fill
  output logic [nps_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [nps_pkg::CfgDataW-1:0]  cfg_data_i
);

  nps_pkg::cmd_t    cmd;
  nps_pkg::status_t status;
  logic [$clog2(SLOTS)-1:0] addr;

  // registers only change between ticks
  assign cfg_ready_o = s_axis_tready;

  nps_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .addr_o     (addr)
  );

  nps_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== hdl/nps_checker.sv =====
// Port-level checker for the priority scheduler, bound to the top level.
// Depends on nps_pkg.
module nps_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [nps_pkg::OutDataW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while a tick is in work");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[97] |-> m_axis_tdata[45:41] == 5'd0)
    else $error("all_idle with ready jobs");

  a_disp_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[46] |-> m_axis_tdata[0] &&
    m_axis_tdata[16:1] == m_axis_tdata[62:47])
    else $error("dispatched job is not the running job");

endmodule

bind nonpreemptive_priority_scheduler_aging nps_checker u_nps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
